>>> hw/rtl/iq_complex_ratio_divider_unit_macros.svh
// Assertion macros shared by the RTL of the complex ratio divider.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef IQ_COMPLEX_RATIO_DIVIDER_UNIT_MACROS_SVH
`define IQ_COMPLEX_RATIO_DIVIDER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ICRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("icrd assertion failed");
// Next-cycle implication.
`define ICRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("icrd assertion failed");
`else
`define ICRD_ASSERT_IMP(lbl, ante, cons)
`define ICRD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/icrd_pkg.sv
package icrd_pkg;

  // Width of each quotient word and the number of quotient bits produced.
  localparam int unsigned QUOT_W = 32;

  // Queue between the front and the back part.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;

  // Saturation limits of a 32-bit signed result.
  localparam logic [QUOT_W-1:0] POS_SAT = 32'h7FFF_FFFF;
  localparam logic [QUOT_W-1:0] NEG_SAT = 32'h8000_0000;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> hw/rtl/icrd_queue.sv
`include "iq_complex_ratio_divider_unit_macros.svh"

module icrd_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      pop_data,
  output icrd_pkg::q_status_t   status
);

  logic [WIDTH-1:0]          mem_r [0:icrd_pkg::Q_DEPTH-1];
  logic [icrd_pkg::Q_AW-1:0] wr_ptr_r;
  logic [icrd_pkg::Q_AW-1:0] rd_ptr_r;
  logic [icrd_pkg::Q_AW:0]   cnt_r;
  logic [icrd_pkg::Q_AW:0]   cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data     = mem_r[rd_ptr_r];
  assign status.full  = (cnt_r == (icrd_pkg::Q_AW + 1)'(icrd_pkg::Q_DEPTH));
  assign status.empty = (cnt_r == '0);

  `ICRD_ASSERT_IMP(a_no_overflow, push, !status.full)
  `ICRD_ASSERT_IMP(a_no_underflow, pop, !status.empty)
  `ICRD_ASSERT_NXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule

>>> hw/rtl/icrd_front.sv
module icrd_front #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_ref_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_ref_q,
  input  logic signed [SAMPLE_WIDTH-1:0] in_flt_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_flt_q,
  input  icrd_pkg::q_status_t            q_status,
  output logic                           push,
  output logic [6*SAMPLE_WIDTH+2:0]      push_data
);

  // Products, the denominator and the numerator magnitudes are all PW bits.
  localparam int unsigned PW = 2 * SAMPLE_WIDTH;

  logic adv;

  logic                           f1_vld_r;
  logic signed [SAMPLE_WIDTH-1:0] f1_di_r;
  logic signed [SAMPLE_WIDTH-1:0] f1_dq_r;
  logic signed [SAMPLE_WIDTH-1:0] f1_fi_r;
  logic signed [SAMPLE_WIDTH-1:0] f1_fq_r;

  logic                 f2_vld_r;
  logic signed [PW-1:0] f2_didi_r;
  logic signed [PW-1:0] f2_dqdq_r;
  logic signed [PW-1:0] f2_fidi_r;
  logic signed [PW-1:0] f2_fqdq_r;
  logic signed [PW-1:0] f2_fqdi_r;
  logic signed [PW-1:0] f2_fidq_r;

  logic               f3_vld_r;
  logic [PW-1:0]      f3_den_r;
  logic signed [PW:0] f3_re_r;
  logic signed [PW:0] f3_im_r;

  logic          f4_vld_r;
  logic          f4_nz_r;
  logic [PW-1:0] f4_den_r;
  logic [PW-1:0] f4_mre_r;
  logic [PW-1:0] f4_mim_r;
  logic          f4_nre_r;
  logic          f4_nim_r;

  // The whole front moves together; it holds only when its last stage
  // has an item and the queue has no room for it.
  assign adv      = !(f4_vld_r && q_status.full);
  assign in_stall = !adv;
  assign push     = f4_vld_r && !q_status.full;
  assign push_data = {f4_nz_r, f4_den_r, f4_mre_r, f4_mim_r, f4_nre_r, f4_nim_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
      f3_vld_r <= 1'b0;
      f4_vld_r <= 1'b0;
    end else if (adv) begin
      f1_vld_r <= in_valid;
      f2_vld_r <= f1_vld_r;
      f3_vld_r <= f2_vld_r;
      f4_vld_r <= f3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_di_r <= in_ref_i;
      f1_dq_r <= in_ref_q;
      f1_fi_r <= in_flt_i;
      f1_fq_r <= in_flt_q;

      f2_didi_r <= PW'(f1_di_r) * PW'(f1_di_r);
      f2_dqdq_r <= PW'(f1_dq_r) * PW'(f1_dq_r);
      f2_fidi_r <= PW'(f1_fi_r) * PW'(f1_di_r);
      f2_fqdq_r <= PW'(f1_fq_r) * PW'(f1_dq_r);
      f2_fqdi_r <= PW'(f1_fq_r) * PW'(f1_di_r);
      f2_fidq_r <= PW'(f1_fi_r) * PW'(f1_dq_r);

      f3_den_r <= $unsigned(f2_didi_r) + $unsigned(f2_dqdq_r);
      f3_re_r  <= (PW + 1)'(f2_fidi_r) + (PW + 1)'(f2_fqdq_r);
      f3_im_r  <= (PW + 1)'(f2_fqdi_r) - (PW + 1)'(f2_fidq_r);

      f4_nz_r  <= (f3_den_r != '0);
      f4_den_r <= f3_den_r;
      f4_nre_r <= f3_re_r[PW];
      f4_nim_r <= f3_im_r[PW];
      f4_mre_r <= f3_re_r[PW] ? PW'(-f3_re_r) : PW'(f3_re_r);
      f4_mim_r <= f3_im_r[PW] ? PW'(-f3_im_r) : PW'(f3_im_r);
    end
  end

endmodule

>>> hw/rtl/icrd_back.sv
`include "iq_complex_ratio_divider_unit_macros.svh"

module icrd_back #(
  parameter int unsigned SAMPLE_WIDTH = 24,
  parameter int unsigned FRAC_BITS    = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [6*SAMPLE_WIDTH+2:0]   pop_data,
  input  icrd_pkg::q_status_t         q_status,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_valid_res,
  output logic signed [31:0]          out_ratio_real,
  output logic signed [31:0]          out_ratio_imag,
  output logic                        out_clipped
);

  localparam int unsigned DW   = 2 * SAMPLE_WIDTH;
  localparam int unsigned QW   = icrd_pkg::QUOT_W;
  localparam int unsigned EW   = DW + FRAC_BITS + QW;
  localparam int unsigned NSTG = QW;

  logic adv;

  // Queue head fields.
  logic          hd_nz;
  logic [DW-1:0] hd_den;
  logic [DW-1:0] hd_mag [0:1];
  logic          hd_neg [0:1];

  // Load stage values.
  logic [DW-1:0] ld_rem [0:1];
  logic [QW-1:0] ld_low [0:1];
  logic          ld_ovf [0:1];

  // Divider pipeline, stage 0 is the load stage.
  logic          vld_r [0:NSTG];
  logic          nz_r  [0:NSTG];
  logic [DW-1:0] den_r [0:NSTG];
  logic [DW-1:0] rem_r [0:NSTG][0:1];
  logic [QW-1:0] low_r [0:NSTG][0:1];
  logic [QW-1:0] q_r   [0:NSTG][0:1];
  logic          neg_r [0:NSTG][0:1];
  logic          ovf_r [0:NSTG][0:1];

  // Rounding stage.
  logic          rd_vld_r;
  logic          rd_nz_r;
  logic [QW-1:0] rd_q_r   [0:1];
  logic          rd_up_r  [0:1];
  logic          rd_neg_r [0:1];
  logic          rd_ovf_r [0:1];

  // Output stage.
  logic          out_valid_r;
  logic          out_vres_r;
  logic [QW-1:0] out_real_r;
  logic [QW-1:0] out_imag_r;
  logic          out_clip_r;
  logic [QW-1:0] fin_val_nxt [0:1];
  logic          fin_sat_nxt [0:1];

  assign adv = !(out_valid_r && out_stall);
  assign pop = adv && !q_status.empty;

  assign hd_nz     = pop_data[3*DW+2];
  assign hd_den    = pop_data[3*DW+1:2*DW+2];
  assign hd_mag[0] = pop_data[2*DW+1:DW+2];
  assign hd_mag[1] = pop_data[DW+1:2];
  assign hd_neg[0] = pop_data[1];
  assign hd_neg[1] = pop_data[0];

  // The scaled numerator n * 2^FRAC_BITS splits into a top part, which is
  // the starting partial remainder, and a 32-bit low word whose bits are
  // brought down one per step. A top part not below the denominator means
  // the quotient needs more than 32 bits.
  always_comb begin
    logic [EW-1:0] n_ext;
    logic [DW:0]   r0;
    for (int l = 0; l < 2; l++) begin
      n_ext     = EW'(hd_mag[l]) << FRAC_BITS;
      r0        = (DW + 1)'(n_ext[EW-1:QW]);
      ld_ovf[l] = (r0 >= {1'b0, hd_den});
      ld_rem[l] = r0[DW-1:0];
      ld_low[l] = n_ext[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NSTG; k++) begin
        vld_r[k] <= 1'b0;
      end
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= !q_status.empty;
      for (int k = 1; k <= NSTG; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      rd_vld_r    <= vld_r[NSTG];
      out_valid_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nz_r[0]  <= hd_nz;
      den_r[0] <= hd_den;
      for (int l = 0; l < 2; l++) begin
        rem_r[0][l] <= ld_rem[l];
        low_r[0][l] <= ld_low[l];
        q_r[0][l]   <= '0;
        neg_r[0][l] <= hd_neg[l];
        ovf_r[0][l] <= ld_ovf[l];
      end
    end
  end

  // One restoring step per stage: bring down a bit, compare, subtract.
  for (genvar k = 1; k <= NSTG; k++) begin : g_stg
    always_ff @(posedge clk) begin
      if (adv) begin
        nz_r[k]  <= nz_r[k-1];
        den_r[k] <= den_r[k-1];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DW:0] trial;
      logic [DW:0] diff;
      logic        ge;

      always_comb begin
        trial = {rem_r[k-1][l], low_r[k-1][l][QW-1]};
        diff  = trial - {1'b0, den_r[k-1]};
        ge    = (trial >= {1'b0, den_r[k-1]});
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k][l] <= ge ? diff[DW-1:0] : trial[DW-1:0];
          low_r[k][l] <= {low_r[k-1][l][QW-2:0], 1'b0};
          q_r[k][l]   <= {q_r[k-1][l][QW-2:0], ge};
          neg_r[k][l] <= neg_r[k-1][l];
          ovf_r[k][l] <= ovf_r[k-1][l];
        end
      end
    end
  end

  // Round half away from zero on the magnitude: add one when 2r >= d.
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_nz_r <= nz_r[NSTG];
      for (int l = 0; l < 2; l++) begin
        rd_q_r[l]   <= q_r[NSTG][l];
        rd_up_r[l]  <= ({rem_r[NSTG][l], 1'b0} >= {1'b0, den_r[NSTG]});
        rd_neg_r[l] <= neg_r[NSTG][l];
        rd_ovf_r[l] <= ovf_r[NSTG][l];
      end
    end
  end

  always_comb begin
    logic [QW:0] qr;
    logic [QW:0] negq;
    for (int l = 0; l < 2; l++) begin
      qr   = {1'b0, rd_q_r[l]} + (QW + 1)'(rd_up_r[l]);
      negq = -qr;
      if (rd_neg_r[l]) begin
        fin_sat_nxt[l] = rd_ovf_r[l] || qr[QW] || (qr[QW-1] && (qr[QW-2:0] != '0));
        fin_val_nxt[l] = fin_sat_nxt[l] ? icrd_pkg::NEG_SAT : negq[QW-1:0];
      end else begin
        fin_sat_nxt[l] = rd_ovf_r[l] || qr[QW] || qr[QW-1];
        fin_val_nxt[l] = fin_sat_nxt[l] ? icrd_pkg::POS_SAT : qr[QW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_vres_r <= rd_nz_r;
      out_real_r <= rd_nz_r ? fin_val_nxt[0] : '0;
      out_imag_r <= rd_nz_r ? fin_val_nxt[1] : '0;
      out_clip_r <= rd_nz_r && (fin_sat_nxt[0] || fin_sat_nxt[1]);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_valid_res  = out_vres_r;
  assign out_ratio_real = $signed(out_real_r);
  assign out_ratio_imag = $signed(out_imag_r);
  assign out_clipped    = out_clip_r;

  `ICRD_ASSERT_IMP(a_skip_zero, out_valid_r && !out_vres_r,
                   (out_real_r == '0) && (out_imag_r == '0) && !out_clip_r)
  `ICRD_ASSERT_IMP(a_clip_sat, out_valid_r && out_clip_r,
                   (out_real_r == icrd_pkg::POS_SAT) || (out_real_r == icrd_pkg::NEG_SAT) ||
                   (out_imag_r == icrd_pkg::POS_SAT) || (out_imag_r == icrd_pkg::NEG_SAT))
  `ICRD_ASSERT_NXT(a_back_frozen, out_valid_r && out_stall, vld_r[0] == $past(vld_r[0]))

endmodule

>>> hw/rtl/iq_complex_ratio_divider_unit.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    ref_i, ref_q, flt_i, flt_q
// out_      output     out_valid / out_stall  valid_res, ratio_real, ratio_imag, clipped
//
// One transaction is accepted per cycle and one result leaves per cycle when neither
// side stalls. A result passes through four front stages, one queue slot, a load
// stage, 32 divider stages, rounding and the output register.
// Reset (rst_n low at a clock edge) empties every stage and the queue, with no clearing pass.
// out_stall freezes the back part; the four-entry queue absorbs the front, which raises
// in_stall once the queue is full and its last stage is loaded.
module iq_complex_ratio_divider_unit #(
  parameter int unsigned SAMPLE_WIDTH = 24,
  parameter int unsigned FRAC_BITS    = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_ref_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_ref_q,
  input  logic signed [SAMPLE_WIDTH-1:0] in_flt_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_flt_q,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_valid_res,
  output logic signed [31:0]             out_ratio_real,
  output logic signed [31:0]             out_ratio_imag,
  output logic                           out_clipped
);

  // Queue entry: nonzero flag, denominator, two numerator magnitudes and
  // their two signs.
  localparam int unsigned QE_W = 6 * SAMPLE_WIDTH + 3;

  icrd_pkg::q_status_t q_status;
  logic                push;
  logic [QE_W-1:0]     push_data;
  logic                pop;
  logic [QE_W-1:0]     pop_data;

  // The front registers the samples, forms the six products, sums them
  // into the denominator and the two numerators, and classifies each point
  // (zero denominator, numerator signs) before it enters the queue.
  icrd_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_ref_i     (in_ref_i),
    .in_ref_q     (in_ref_q),
    .in_flt_i     (in_flt_i),
    .in_flt_q     (in_flt_q),
    .q_status     (q_status),
    .push         (push),
    .push_data    (push_data)
  );

  icrd_queue #(
    .WIDTH(QE_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .status   (q_status)
  );

  // The back divides both numerators by the shared denominator, one
  // quotient bit per stage, then rounds, saturates and registers the result.
  icrd_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_data      (pop_data),
    .q_status      (q_status),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res),
    .out_ratio_real(out_ratio_real),
    .out_ratio_imag(out_ratio_imag),
    .out_clipped   (out_clipped)
  );

endmodule

>>> tb/iq_complex_ratio_divider_unit_tb.sv
`default_nettype none

module iq_complex_ratio_divider_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default widths; the predictor uses the same values.
  localparam int unsigned SW        = 24;
  localparam int unsigned FB        = 24;
  localparam int          N_RANDOM  = 1200;
  // The final drain waits after the last result so that any stray result still has
  // time to show up.
  localparam int          DRAIN_CYC = 80;

  typedef logic signed [SW-1:0] sample_t;

  // One expected result of the divider.
  typedef struct packed {
    logic        valid_res;
    logic [31:0] ratio_real;
    logic [31:0] ratio_imag;
    logic        clipped;
  } ratio_t;

  // One row of the directed table. Where typed is set, the expected result is
  // written out in the row itself; otherwise the predictor supplies it.
  typedef struct {
    sample_t di;
    sample_t dq;
    sample_t fi;
    sample_t fq;
    bit      typed;
    ratio_t  res;
  } sweep_row_t;

  localparam sample_t S_MAX = sample_t'((1 << (SW - 1)) - 1);
  localparam sample_t S_MIN = sample_t'(-(1 << (SW - 1)));

  logic    clk           = 1'b0;
  logic    rst_n         = 1'b0;
  logic    in_valid      = 1'b0;
  logic    in_stall;
  sample_t in_ref_i      = '0;
  sample_t in_ref_q      = '0;
  sample_t in_flt_i      = '0;
  sample_t in_flt_q      = '0;
  logic    out_valid;
  logic    out_stall     = 1'b0;
  logic    out_valid_res;
  logic signed [31:0] out_ratio_real;
  logic signed [31:0] out_ratio_imag;
  logic    out_clipped;

  iq_complex_ratio_divider_unit #(
    .SAMPLE_WIDTH(SW),
    .FRAC_BITS   (FB)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_ref_i     (in_ref_i),
    .in_ref_q     (in_ref_q),
    .in_flt_i     (in_flt_i),
    .in_flt_q     (in_flt_q),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_valid_res(out_valid_res),
    .out_ratio_real(out_ratio_real),
    .out_ratio_imag(out_ratio_imag),
    .out_clipped  (out_clipped)
  );

  // Free-running 2 ns clock.
  initial begin
    forever #1 clk = ~clk;
  end

  // Hard limit on the run. The slowest correct run is well under 200 us, even
  // with the longest sender gaps and receiver stall stretches on every point.
  initial begin
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Scales one exact numerator by 2^FB, divides by the denominator, rounds to
  // nearest with halves going away from zero, and saturates to 32 bits. The
  // top bit of the return value is the saturation flag for this part.
  function automatic logic [32:0] scale_ratio_part(longint num, longint den);
    logic [127:0] mag;
    logic [127:0] quo;
    logic [127:0] rem;
    logic [127:0] den_w;
    logic         neg;
    neg   = (num < 0);
    mag   = neg ? 128'(-num) : 128'(num);
    den_w = 128'(den);
    mag   = mag << FB;
    quo   = mag / den_w;
    rem   = mag % den_w;
    // The sign is applied after the magnitude has been rounded.
    if ((rem << 1) >= den_w) quo = quo + 1;
    if (neg) begin
      if (quo > 128'h8000_0000) return {1'b1, 32'h8000_0000};
      return {1'b0, 32'(-quo[31:0])};
    end
    if (quo > 128'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, quo[31:0]};
  endfunction

  // Complex ratio filtered/direct for one sweep point.
  function automatic ratio_t predict_sweep_ratio(sample_t di, sample_t dq,
                                                 sample_t fi, sample_t fq);
    longint      sdi;
    longint      sdq;
    longint      sfi;
    longint      sfq;
    longint      den;
    logic [32:0] re_part;
    logic [32:0] im_part;
    ratio_t      res;
    sdi = longint'(di);
    sdq = longint'(dq);
    sfi = longint'(fi);
    sfq = longint'(fq);
    den = sdi * sdi + sdq * sdq;
    // A reference of zero magnitude skips the point with all parts cleared.
    if (den == 0) return '0;
    re_part = scale_ratio_part(sfi * sdi + sfq * sdq, den);
    im_part = scale_ratio_part(sfq * sdi - sfi * sdq, den);
    res.valid_res  = 1'b1;
    res.ratio_real = re_part[31:0];
    res.ratio_imag = im_part[31:0];
    res.clipped    = re_part[32] | im_part[32];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  sweep_row_t sweep_rows[$];
  ratio_t     pending_ratios[$];   // results still owed by the block, oldest first
  int         n_total   = 0;
  int         n_sent    = 0;
  int         errors    = 0;
  int         n_results = 0;
  int         n_skipped = 0;
  int         n_clipped = 0;

  task automatic add_row(sample_t di, sample_t dq, sample_t fi, sample_t fq,
                         bit typed, logic vr, logic [31:0] re, logic [31:0] im,
                         logic cl);
    sweep_row_t row;
    row.di    = di;
    row.dq    = dq;
    row.fi    = fi;
    row.fq    = fq;
    row.typed = typed;
    row.res   = '{valid_res: vr, ratio_real: re, ratio_imag: im, clipped: cl};
    sweep_rows.push_back(row);
  endtask

  function automatic sample_t rand_sample();
    logic [31:0] w;
    w = $urandom;
    return w[SW-1:0];
  endfunction

  function automatic sample_t rand_small(int span);
    return sample_t'($urandom_range(0, 2 * span) - span);
  endfunction

  // Corner values of a sample: both extremes, one above the minimum, zero and unit magnitudes.
  function automatic sample_t rand_corner();
    case ($urandom_range(0, 5))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3:       return sample_t'(1);
      4:       return sample_t'(-1);
      default: return sample_t'(S_MIN + 1);
    endcase
  endfunction

  // Random sweep points. The mix leans on the cases that exercise rounding and
  // saturation, with a share of fully random points so that every input bit
  // toggles and a share of zero references.
  task automatic gen_random_point(output sample_t di, output sample_t dq,
                                  output sample_t fi, output sample_t fq);
    int mode;
    mode = $urandom_range(0, 9);
    di = rand_sample();
    dq = rand_sample();
    fi = rand_sample();
    fq = rand_sample();
    case (mode)
      4: begin
        // Small values: short repeating fractions, so rounding decides the LSB.
        di = rand_small(9);
        dq = rand_small(9);
        fi = rand_small(9);
        fq = rand_small(9);
      end
      5: begin
        // Weak reference against a strong filtered path: mostly saturation.
        di = rand_small(20);
        dq = rand_small(20);
      end
      6: begin
        // Zero reference: the point must be skipped whatever the filtered path holds.
        di = '0;
        dq = '0;
      end
      7: begin
        di = rand_corner();
        dq = rand_corner();
        fi = rand_corner();
        fq = rand_corner();
      end
      8: begin
        // Filtered close to the reference: ratios near one, no clipping.
        fi = sample_t'(int'(di) + int'(rand_small(300)));
        fq = sample_t'(int'(dq) + int'(rand_small(300)));
      end
      9: begin
        // Purely real or purely imaginary reference.
        if ($urandom_range(0, 1) == 0) di = '0;
        else dq = '0;
      end
      default: begin
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of transactions of random length separated by random gaps.
  // ---------------------------------------------------------------------------

  int     next_idx   = 0;
  int     burst_left = 1;
  int     gap_left   = 0;
  bit     cur_typed  = 1'b0;
  ratio_t cur_res    = '0;

  always @(posedge clk) begin
    sweep_row_t row;
    sample_t    di;
    sample_t    dq;
    sample_t    fi;
    sample_t    fq;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // A transaction completes at this edge: record what it must produce.
      if (in_valid && !in_stall) begin
        if (cur_typed) pending_ratios.push_back(cur_res);
        else pending_ratios.push_back(predict_sweep_ratio(in_ref_i, in_ref_q,
                                                          in_flt_i, in_flt_q));
        n_sent++;
      end
      if (in_valid && in_stall) begin
        // The block is holding off; the payload stays as it is.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (next_idx < n_total) begin
        if (next_idx < sweep_rows.size()) begin
          row       = sweep_rows[next_idx];
          di        = row.di;
          dq        = row.dq;
          fi        = row.fi;
          fq        = row.fq;
          cur_typed = row.typed;
          cur_res   = row.res;
        end else begin
          gen_random_point(di, dq, fi, fq);
          cur_typed = 1'b0;
        end
        in_ref_i <= di;
        in_ref_q <= dq;
        in_flt_i <= fi;
        in_flt_q <= fq;
        in_valid <= 1'b1;
        next_idx++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          // About a third of the bursts run straight into the next one.
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern that changes mode at random intervals, from
  // no stall at all to long stretches of mostly stalled cycles.
  // ---------------------------------------------------------------------------

  int stall_mode = 0;
  int mode_left  = 0;
  int mode_phase = 0;
  int mode_per   = 3;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 4);
        mode_left  = $urandom_range(20, 300);
        mode_per   = $urandom_range(2, 9);
        mode_phase = 0;
      end
      mode_left--;
      mode_phase++;
      case (stall_mode)
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        3:       out_stall <= ((mode_phase % mode_per) == 0);
        4:       out_stall <= ((mode_phase % 64) < 40);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every result transaction is compared with the oldest expectation.
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    ratio_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ratios.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %b %h %h %b", $realtime,
                 out_valid_res, out_ratio_real, out_ratio_imag, out_clipped);
      end else begin
        want = pending_ratios.pop_front();
        check_field("valid_res", 32'(want.valid_res), 32'(out_valid_res));
        check_field("ratio_real", want.ratio_real, out_ratio_real);
        check_field("ratio_imag", want.ratio_imag, out_ratio_imag);
        check_field("clipped", 32'(want.clipped), 32'(out_clipped));
        n_results++;
        if (!want.valid_res) n_skipped++;
        if (want.clipped) n_clipped++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Zero reference: skipped, whatever the filtered path holds.
    add_row('0, '0, '0, '0, 1, 1'b0, 32'h0, 32'h0, 1'b0);
    add_row('0, '0, S_MAX, S_MIN, 1, 1'b0, 32'h0, 32'h0, 1'b0);
    // Unit reference: the ratio is the filtered sample scaled by 2^FB.
    add_row(sample_t'(1), '0, sample_t'(1), '0, 1, 1'b1, 32'h0100_0000, 32'h0, 1'b0);
    add_row(sample_t'(1), '0, '0, sample_t'(1), 1, 1'b1, 32'h0, 32'h0100_0000, 1'b0);
    add_row(sample_t'(1), '0, '0, '0, 1, 1'b1, 32'h0, 32'h0, 1'b0);
    // Reference j, filtered 1: the ratio is -j.
    add_row('0, sample_t'(1), sample_t'(1), '0, 1, 1'b1, 32'h0, 32'hFF00_0000, 1'b0);
    // Saturation at both ends.
    add_row(sample_t'(1), '0, S_MAX, S_MIN, 1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    add_row(sample_t'(1), '0, S_MIN, S_MAX, 1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    // Exactly 2^31 clips on the positive side; exactly -2^31 fits on the negative side.
    add_row(sample_t'(1), '0, sample_t'(128), '0, 1, 1'b1, 32'h7FFF_FFFF, 32'h0, 1'b1);
    add_row(sample_t'(1), '0, sample_t'(127), sample_t'(-128), 1, 1'b1,
            32'h7F00_0000, 32'h8000_0000, 1'b0);
    // Largest references with equal filtered samples: the ratio is exactly one.
    add_row(S_MIN, S_MIN, S_MIN, S_MIN, 1, 1'b1, 32'h0100_0000, 32'h0, 1'b0);
    add_row(S_MAX, S_MAX, S_MAX, S_MAX, 1, 1'b1, 32'h0100_0000, 32'h0, 1'b0);
    add_row(sample_t'(2), '0, sample_t'(1), '0, 1, 1'b1, 32'h0080_0000, 32'h0, 1'b0);
    // Rows below rely on the predictor: rounding of repeating fractions in both
    // signs, tiny quotients and alternating bit patterns.
    add_row(sample_t'(3), '0, sample_t'(1), '0, 0, 1'b0, '0, '0, 1'b0);
    add_row(sample_t'(3), '0, sample_t'(2), sample_t'(-2), 0, 1'b0, '0, '0, 1'b0);
    add_row(sample_t'(-3), sample_t'(1), sample_t'(-2), sample_t'(5), 0, 1'b0, '0, '0, 1'b0);
    add_row(S_MIN, '0, S_MAX, '0, 0, 1'b0, '0, '0, 1'b0);
    add_row(S_MAX, '0, sample_t'(1), sample_t'(-1), 0, 1'b0, '0, '0, 1'b0);
    add_row(S_MIN, S_MAX, sample_t'(1), sample_t'(-1), 0, 1'b0, '0, '0, 1'b0);
    add_row('0, S_MIN, '0, S_MAX, 0, 1'b0, '0, '0, 1'b0);
    add_row(sample_t'(24'h555555), sample_t'(24'hAAAAAA), sample_t'(24'hAAAAAA),
            sample_t'(24'h555555), 0, 1'b0, '0, '0, 1'b0);
    add_row(sample_t'(-1), sample_t'(-1), sample_t'(1), sample_t'(1), 0, 1'b0, '0, '0, 1'b0);
    add_row(sample_t'(7), sample_t'(-5), S_MAX, S_MAX, 0, 1'b0, '0, '0, 1'b0);
    n_total = sweep_rows.size() + N_RANDOM;

    // Synchronous reset held low from the start, then released once.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every transaction to go in and every result to come out.
    while (n_sent < n_total || pending_ratios.size() != 0) @(posedge clk);
    // Then give the pipeline time to show any result nobody asked for.
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Covered %0d sweep points (%0d directed, %0d random), %0d results checked.",
             n_sent, sweep_rows.size(), n_sent - sweep_rows.size(), n_results);
    $display("Of these, %0d were skipped for a zero reference and %0d saturated.",
             n_skipped, n_clipped);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
